// File: rtl/core/fresnel_kernel_generator_defines.svh
// Assertion macros shared by the kernel generator RTL.
`ifndef FRESNEL_KERNEL_GENERATOR_DEFINES_SVH
`define FRESNEL_KERNEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FKG_ASSERT_IMP(label, clock, resetn, pre, post, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FKG_ASSERT_NXT(label, clock, resetn, pre, post, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/fkg_pkg.sv
`timescale 1ns / 1ps
package fkg_pkg;

    localparam int MAX_SIZE     = 1024;
    localparam int OUT_BITS     = 16;

    localparam int SIZE_W       = $clog2(MAX_SIZE + 1);
    localparam int IDX_W        = $clog2(MAX_SIZE);
    localparam int DIFF_W       = SIZE_W + 1;
    // |2*index - size| stays below 2^SIZE_W
    localparam int SQ_W         = 2 * SIZE_W;
    localparam int PHASE_W      = 32;
    localparam int XY_W         = 32;
    localparam int FRAC_BITS    = 30;
    localparam int CORDIC_STEPS = 20;
    // OUT_BITS up to 30: the output keeps fewer fraction bits than the datapath
    localparam int ROUND_SH     = FRAC_BITS - (OUT_BITS - 1);
    // input regs, square, multiply, quadrant split, CORDIC steps, rounding
    localparam int LATENCY      = 4 + CORDIC_STEPS + 1;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X  = 2'd0,
        REG_SIZE_Y  = 2'd1,
        REG_COEFF_X = 2'd2,
        REG_COEFF_Y = 2'd3
    } fkg_reg_t;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } fkg_quad_t;

    typedef struct packed {
        logic [IDX_W-1:0] col_index;
        logic [IDX_W-1:0] row_index;
    } fkg_request_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] cos_part;
        logic signed [OUT_BITS-1:0] sin_part;
    } fkg_result_t;

    typedef struct packed {
        logic                      valid;
        fkg_quad_t                 quad;
        logic signed [PHASE_W-1:0] angle;
    } fkg_phase_t;

    typedef struct packed {
        logic                      valid;
        fkg_quad_t                 quad;
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [PHASE_W-1:0] angle;
    } fkg_rot_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic signed [PHASE_W-1:0] atan_turn(input int idx);
        logic signed [PHASE_W-1:0] a;
        case (idx)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/fkg_phase.sv
`timescale 1ns / 1ps
module fkg_phase
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  fkg_pkg::fkg_request_t       request,
    input  logic [fkg_pkg::SIZE_W-1:0]  size_x,
    input  logic [fkg_pkg::SIZE_W-1:0]  size_y,
    input  logic [fkg_pkg::PHASE_W-1:0] coeff_x,
    input  logic [fkg_pkg::PHASE_W-1:0] coeff_y,
    output fkg_pkg::fkg_phase_t         phase
);
    import fkg_pkg::*;

    localparam logic [PHASE_W-1:0] EIGHTH = PHASE_W'(1) << (PHASE_W - 3);

    // stage 1: offsets from grid center
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    // stage 2: squares
    logic                     v2_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    // stage 3: per-axis phase
    logic                     v3_reg;
    logic [PHASE_W-1:0]       px_reg, py_reg;
    logic [PHASE_W+SQ_W-1:0]  px_full, py_full;
    // stage 4: quadrant split
    logic [PHASE_W-1:0]       turns, shifted, resid;
    logic                     phase_valid_reg;
    fkg_phase_t               phase_reg, phase_next;

    assign dx_next = $signed({1'b0, request.col_index, 1'b0}) - $signed({1'b0, size_x});
    assign dy_next = $signed({1'b0, request.row_index, 1'b0}) - $signed({1'b0, size_y});

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    assign px_full = coeff_x * sqx_reg;
    assign py_full = coeff_y * sqy_reg;

    always_comb
    begin
        turns   = PHASE_W'(0) - (px_reg + py_reg);
        shifted = turns + EIGHTH;
        phase_next.valid = v3_reg;
        phase_next.quad  = fkg_quad_t'(shifted[PHASE_W-1 -: 2]);
        resid = turns - {shifted[PHASE_W-1 -: 2], {(PHASE_W-2){1'b0}}};
        phase_next.angle = $signed(resid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            phase_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg          <= accept;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            phase_valid_reg <= phase_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sqx_reg   <= sqx_full[SQ_W-1:0];
        sqy_reg   <= sqy_full[SQ_W-1:0];
        px_reg    <= px_full[PHASE_W-1:0];
        py_reg    <= py_full[PHASE_W-1:0];
        phase_reg <= phase_next;
    end

    // take the valid bit from the reset register
    always_comb
    begin
        phase       = phase_reg;
        phase.valid = phase_valid_reg;
    end

endmodule

// File: rtl/core/fkg_cordic.sv
`timescale 1ns / 1ps
`include "fresnel_kernel_generator_defines.svh"
module fkg_cordic
(
    input  logic                clk,
    input  logic                rst_n,
    input  fkg_pkg::fkg_phase_t phase,
    output fkg_pkg::fkg_rot_t   rotated
);
    import fkg_pkg::*;

    logic                      vld_reg   [CORDIC_STEPS];
    fkg_quad_t                 quad_reg  [CORDIC_STEPS];
    logic signed [XY_W-1:0]    x_reg     [CORDIC_STEPS];
    logic signed [XY_W-1:0]    y_reg     [CORDIC_STEPS];
    logic signed [PHASE_W-1:0] angle_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [PHASE_W-1:0] ANGLE = atan_turn(i);

        logic                      vin;
        fkg_quad_t                 qin;
        logic signed [XY_W-1:0]    xin, yin;
        logic signed [PHASE_W-1:0] zin;

        if (i == 0)
        begin : g_first
            assign vin = phase.valid;
            assign qin = phase.quad;
            assign xin = CORDIC_X0;
            assign yin = '0;
            assign zin = phase.angle;
        end
        else
        begin : g_next
            assign vin = vld_reg[i-1];
            assign qin = quad_reg[i-1];
            assign xin = x_reg[i-1];
            assign yin = y_reg[i-1];
            assign zin = angle_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vin;
        end

        // rotate toward zero remaining angle; arithmetic shift is a floor shift
        always_ff @(posedge clk)
        begin
            quad_reg[i] <= qin;
            if (zin >= 0)
            begin
                x_reg[i]     <= xin - (yin >>> i);
                y_reg[i]     <= yin + (xin >>> i);
                angle_reg[i] <= zin - ANGLE;
            end
            else
            begin
                x_reg[i]     <= xin + (yin >>> i);
                y_reg[i]     <= yin - (xin >>> i);
                angle_reg[i] <= zin + ANGLE;
            end
        end
    end

    assign rotated.valid = vld_reg[CORDIC_STEPS-1];
    assign rotated.quad  = quad_reg[CORDIC_STEPS-1];
    assign rotated.x     = x_reg[CORDIC_STEPS-1];
    assign rotated.y     = y_reg[CORDIC_STEPS-1];
    assign rotated.angle = angle_reg[CORDIC_STEPS-1];

    `FKG_ASSERT_IMP(a_valid_delay, clk, rst_n, phase.valid, ##CORDIC_STEPS rotated.valid, "cordic valid lost")
    `FKG_ASSERT_IMP(a_valid_origin, clk, rst_n, rotated.valid, $past(phase.valid, CORDIC_STEPS), "cordic valid invented")
    `FKG_ASSERT_IMP(a_quad_delay, clk, rst_n, rotated.valid, rotated.quad == $past(phase.quad, CORDIC_STEPS), "quadrant out of step with data")
    `FKG_ASSERT_IMP(a_residual, clk, rst_n, rotated.valid, (rotated.angle < 32'sd4096) && (rotated.angle > -32'sd4096), "cordic did not converge")

endmodule

// File: rtl/core/fkg_round.sv
`timescale 1ns / 1ps
module fkg_round
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fkg_pkg::fkg_rot_t    rotated,
    output logic                 done,
    output fkg_pkg::fkg_result_t result
);
    import fkg_pkg::*;

    localparam int WIDE_W = XY_W + 2;
    localparam logic signed [WIDE_W-1:0] HALF    = WIDE_W'(1) <<< (ROUND_SH - 1);
    localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] OUT_MIN = -OUT_MAX - WIDE_W'(1);

    logic signed [WIDE_W-1:0] xe, ye, c, s;
    logic                     done_reg;
    fkg_result_t              result_reg, result_next;

    function automatic logic signed [OUT_BITS-1:0] round_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = (v + HALF) >>> ROUND_SH;
        if (r > OUT_MAX)
            r = OUT_MAX;
        else if (r < OUT_MIN)
            r = OUT_MIN;
        return r[OUT_BITS-1:0];
    endfunction

    assign xe = WIDE_W'(rotated.x);
    assign ye = WIDE_W'(rotated.y);

    // apply the quarter turn exactly
    always_comb
    begin
        case (rotated.quad)
            QUAD_0:
            begin
                c = xe;
                s = ye;
            end
            QUAD_90:
            begin
                c = -ye;
                s = xe;
            end
            QUAD_180:
            begin
                c = -xe;
                s = -ye;
            end
            default:
            begin
                c = ye;
                s = -xe;
            end
        endcase
        result_next.cos_part = round_sat(c);
        result_next.sin_part = round_sat(s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rotated.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/fresnel_kernel_generator.sv
`timescale 1ns / 1ps
// Fresnel transfer-function kernel generator.
// Request: drive start with a column/row index pair in request; it is taken
// at a clock edge where start is high and busy is low. busy is high only in
// the first cycle after reset, so one request can be taken every cycle.
// Result: done pulses for one cycle with cos_part/sin_part of exp(-i*2*pi*t),
// signed Q1.15, t = (coeff_x*dx^2 + coeff_y*dy^2) mod 1 turn,
// dx = 2*col - size_x, dy = 2*row - size_y. +1.0 saturates to the top code.
// The result passes through 4 phase stages (offset, square, coefficient
// multiply, quadrant split), one stage per CORDIC step (20), and one
// rounding stage.
// Throughput: one result per cycle, set by the fully pipelined CORDIC.
// The receiver cannot stall; results are presented once and never held.
// Configuration: cfg_write with cfg_index 0..3 writes size_x, size_y,
// coeff_x, coeff_y; write only while no request is in flight.
// Reset: sizes return to 1024, coefficients to zero, pipeline emptied.
`include "fresnel_kernel_generator_defines.svh"
module fresnel_kernel_generator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fkg_pkg::fkg_request_t          request,
    output logic                           done,
    output fkg_pkg::fkg_result_t           result,
    input  logic                           cfg_write,
    input  logic [fkg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fkg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fkg_pkg::*;

    localparam logic signed [OUT_BITS-1:0] MAG_FLOOR = OUT_BITS'(23000 >> (16 - OUT_BITS + 0));

    logic               busy_reg;
    logic               accept;
    logic [SIZE_W-1:0]  size_x_reg, size_y_reg;
    logic [PHASE_W-1:0] coeff_x_reg, coeff_y_reg;
    fkg_phase_t         phase;
    fkg_rot_t           rotated;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            size_x_reg  <= SIZE_W'(MAX_SIZE);
            size_y_reg  <= SIZE_W'(MAX_SIZE);
            coeff_x_reg <= '0;
            coeff_y_reg <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (fkg_reg_t'(cfg_index))
                    REG_SIZE_X:  size_x_reg  <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_Y:  size_y_reg  <= cfg_data[SIZE_W-1:0];
                    REG_COEFF_X: coeff_x_reg <= cfg_data[PHASE_W-1:0];
                    REG_COEFF_Y: coeff_y_reg <= cfg_data[PHASE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    fkg_phase u_phase
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .size_x  (size_x_reg),
        .size_y  (size_y_reg),
        .coeff_x (coeff_x_reg),
        .coeff_y (coeff_y_reg),
        .phase   (phase)
    );

    fkg_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .phase   (phase),
        .rotated (rotated)
    );

    fkg_round u_round
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rotated (rotated),
        .done    (done),
        .result  (result)
    );

    `FKG_ASSERT_IMP(a_latency, clk, rst_n, accept, ##LATENCY done, "request produced no result")
    `FKG_ASSERT_IMP(a_no_extra, clk, rst_n, done, $past(accept, LATENCY), "result without a request")
    `FKG_ASSERT_NXT(a_busy_stays_low, clk, rst_n, !busy, !busy, "busy rose after reset")
    `FKG_ASSERT_IMP(a_unit_mag, clk, rst_n, done, (result.cos_part > MAG_FLOOR) || (result.cos_part < -MAG_FLOOR) || (result.sin_part > MAG_FLOOR) || (result.sin_part < -MAG_FLOOR), "kernel value far from unit magnitude")

endmodule
